// File: hdl/mpe_pkg.sv
// Shared constants, codes and the exponent constant table for the mixture E-step unit.
package mpe_pkg;

   // Default sizes of the mixture
   localparam int COMPONENTS_DEF    = 8;
   localparam int DIMENSIONS_DEF    = 4;
   localparam int DISCRETE_VARS_DEF = 2;
   localparam int CATEGORIES_DEF    = 8;

   // Fixed-point constants (Q16)
   localparam int HALF_LOG_2PI = 60224;
   localparam int LN2_Q16      = 45426;
   localparam int LOG2E_Q16    = 94548;

   // Accumulator and result widths
   localparam int ACC_W  = 40;
   localparam int POST_W = 17;

   // Exponent constant table: 16 steps of 31 bits each
   localparam int EXP_STEPS = 16;
   localparam int EXP_CW    = 31;

   // Input word opcodes
   typedef enum logic [1:0] {
      OP_LOAD_MEAN  = 2'd0,
      OP_LOAD_COUNT = 2'd1,
      OP_COORD      = 2'd2,
      OP_CATEGORY   = 2'd3
   } opcode_type;

   // c_i = floor(sqrt(c_(i-1) * 2^30)), c_0 = 2^29: successive roots of one half in Q1.30
   function automatic logic [EXP_STEPS*EXP_CW-1:0] build_exp_consts();
      logic [EXP_STEPS*EXP_CW-1:0] tab;
      logic [63:0] c;
      logic [63:0] x;
      logic [63:0] r;
      logic [63:0] b;
      tab = '0;
      c   = 64'd1 << 29;
      for (int i = 0; i < EXP_STEPS; i++) begin
         x = c << 30;
         r = '0;
         b = 64'd1 << 62;
         for (int j = 0; j < 32; j++) begin
            if (b > x) begin
               b = b >> 2;
            end
         end
         for (int j = 0; j < 32; j++) begin
            if (b != 64'd0) begin
               if (x >= r + b) begin
                  x = x - (r + b);
                  r = (r >> 1) + b;
               end else begin
                  r = r >> 1;
               end
               b = b >> 2;
            end
         end
         c = r;
         tab[i*EXP_CW +: EXP_CW] = c[EXP_CW-1:0];
      end
      return tab;
   endfunction

   localparam logic [EXP_STEPS*EXP_CW-1:0] EXP_CONSTS = build_exp_consts();

endpackage

// File: hdl/mpe_div.sv
// Restoring divider, one quotient bit per cycle, for the posterior normalisation.
module mpe_div #(
   parameter int DEN_W = 36,
   parameter int QUO_W = mpe_pkg::POST_W
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [DEN_W+QUO_W-1:0] num,
   input  logic [DEN_W-1:0]       den,
   output logic                   done,
   output logic [QUO_W-1:0]       quotient
);

   localparam int CNT_W = $clog2(QUO_W + 1);

   logic [DEN_W-1:0] rem_ff;
   logic [QUO_W-1:0] low_ff;
   logic [QUO_W-1:0] quo_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   // trial subtraction of the divisor from the shifted remainder
   logic [DEN_W:0] trial;
   logic           fits;

   assign trial = {rem_ff, low_ff[QUO_W-1]};
   assign fits  = (trial >= {1'b0, den});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            // the quotient fits QUO_W bits, so the top part is already below the divisor
            rem_ff  <= num[DEN_W+QUO_W-1:QUO_W];
            low_ff  <= num[QUO_W-1:0];
            cnt_ff  <= CNT_W'(QUO_W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (fits) begin
               rem_ff <= DEN_W'(trial - {1'b0, den});
            end else begin
               rem_ff <= trial[DEN_W-1:0];
            end
            low_ff <= low_ff << 1;
            quo_ff <= {quo_ff[QUO_W-2:0], fits};
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: hdl/mixture_posterior_estep_unit.sv
// Mixture E-step unit. Load words complete without leaving the idle state: opcode 0 writes
// a component mean, opcode 1 a categorical count. Sample words are worked through one
// component at a time on a single shared registered multiplier: a coordinate reads the mean,
// squares the difference and accumulates, per component; a category sums the count row,
// checks it for zero, then runs up to two normalising shift runs, each followed by bit-serial
// log2 squaring, and accumulates, per component. The word flagged last then scores: the
// totals for every component, the exponent (16 multiply steps) per component, and the
// posterior division and the result word per component, each word waiting for rsp_ready.
// No new word is taken until the current one, and its results, are finished.
module mixture_posterior_estep_unit #(
   parameter int COMPONENTS    = mpe_pkg::COMPONENTS_DEF,
   parameter int DIMENSIONS    = mpe_pkg::DIMENSIONS_DEF,
   parameter int DISCRETE_VARS = mpe_pkg::DISCRETE_VARS_DEF,
   parameter int CATEGORIES    = mpe_pkg::CATEGORIES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_opcode,
   input  logic [2:0]         req_component,
   input  logic [1:0]         req_coordinate,
   input  logic               req_variable,
   input  logic [2:0]         req_category,
   input  logic signed [31:0] req_value,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_component_out,
   output logic signed [31:0] rsp_log_likelihood,
   output logic [16:0]        rsp_posterior,
   output logic               rsp_last_out
);

   localparam int COMP_W     = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;
   localparam int MEAN_DEPTH = COMPONENTS * DIMENSIONS;
   localparam int MEAN_AW    = (MEAN_DEPTH > 1) ? $clog2(MEAN_DEPTH) : 1;
   localparam int CNT_DEPTH  = (COMPONENTS * DISCRETE_VARS * CATEGORIES > 0) ?
                               COMPONENTS * DISCRETE_VARS * CATEGORIES : 1;
   localparam int CNT_AW     = (CNT_DEPTH > 1) ? $clog2(CNT_DEPTH) : 1;
   localparam int CAT_W      = $clog2(CATEGORIES);
   localparam int RS_W       = 31 + $clog2(CATEGORIES);
   localparam int P_W        = $clog2(RS_W);
   localparam int LOG_W      = P_W + 16;
   localparam int SUM_W      = 32 + $clog2(COMPONENTS);
   localparam int NUM_W      = SUM_W + mpe_pkg::POST_W;
   localparam int ACC_W      = mpe_pkg::ACC_W;
   localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
   localparam logic [41:0] NORM_TERM = 42'(DIMENSIONS * mpe_pkg::HALF_LOG_2PI);
   localparam logic signed [31:0] LL_MIN = 32'sh8000_0000;

   typedef enum logic [4:0] {
      S_IDLE,
      S_MEAN_RD,
      S_MEAN_MUL,
      S_MEAN_ACC,
      S_ROW_RD,
      S_ROW_ADD,
      S_LOG_START,
      S_LOG_NORM,
      S_LOG_SQ,
      S_LOG_CHK,
      S_DISC_MUL,
      S_DISC_ACC,
      S_SCORE,
      S_EXP_MUL,
      S_EXP_Q,
      S_EXP_MULC,
      S_EXP_UPD,
      S_EXP_DONE,
      S_DIV_GO,
      S_DIV_WAIT,
      S_OUT
   } state_type;

   state_type state_ff;

   // sample word fields held while it is worked on
   logic [COMP_W-1:0]  k_ff;
   logic [CAT_W-1:0]   c_ff;
   logic [CAT_W-1:0]   sel_ff;
   logic [3:0]         j_ff;
   logic [1:0]         coord_ff;
   logic               var_ff;
   logic signed [31:0] x_ff;
   logic               last_ff;

   // discrete term working registers
   logic [RS_W-1:0]  rowsum_ff;
   logic [30:0]      cnt_ff;
   logic [RS_W-1:0]  lw_ff;
   logic [P_W-1:0]   lp_ff;
   logic [30:0]      lm_ff;
   logic [15:0]      lfrac_ff;
   logic             lpass_ff;
   logic [LOG_W-1:0] lr_ff;

   // per-component accumulators and scores
   logic [ACC_W-1:0]   dist_ff [COMPONENTS];
   logic [ACC_W-1:0]   disc_ff [COMPONENTS];
   logic signed [31:0] ll_ff   [COMPONENTS];
   logic [30:0]        ex_ff   [COMPONENTS];
   logic signed [31:0] best_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [30:0]        e_ff;
   logic [4:0]         q_ff;
   logic [15:0]        f_ff;

   // result word register
   logic               rsp_valid_ff;
   logic [2:0]         rsp_comp_ff;
   logic signed [31:0] rsp_ll_ff;
   logic [16:0]        rsp_post_ff;
   logic               rsp_last_ff;

   // shared multiplier
   logic [32:0] mul_a;
   logic [32:0] mul_b;
   logic [65:0] prod_ff;

   logic accept;
   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);

   // ---------------- tables ----------------
   logic [31:0]        mean_mem [MEAN_DEPTH];
   logic [31:0]        cnt_mem  [CNT_DEPTH];
   logic [31:0]        mean_rd_ff;
   logic [31:0]        cnt_rd_ff;
   logic               mean_we;
   logic               cnt_we;
   logic [MEAN_AW-1:0] mean_waddr;
   logic [MEAN_AW-1:0] mean_raddr;
   logic [CNT_AW-1:0]  cnt_waddr;
   logic [CNT_AW-1:0]  cnt_raddr;

   assign mean_we = accept && (req_opcode == mpe_pkg::OP_LOAD_MEAN)
                    && (int'(req_component) < COMPONENTS)
                    && (int'(req_coordinate) < DIMENSIONS);
   assign cnt_we  = accept && (req_opcode == mpe_pkg::OP_LOAD_COUNT)
                    && (int'(req_component) < COMPONENTS)
                    && (int'(req_variable) < DISCRETE_VARS)
                    && (int'(req_category) < CATEGORIES);
   assign mean_waddr = MEAN_AW'(int'(req_component) * DIMENSIONS + int'(req_coordinate));
   assign mean_raddr = MEAN_AW'(int'(k_ff) * DIMENSIONS + int'(coord_ff));
   assign cnt_waddr  = CNT_AW'((int'(req_component) * DISCRETE_VARS + int'(req_variable))
                               * CATEGORIES + int'(req_category));
   assign cnt_raddr  = CNT_AW'((int'(k_ff) * DISCRETE_VARS + int'(var_ff))
                               * CATEGORIES + int'(c_ff));

   always_ff @(posedge clock) begin
      if (mean_we) begin
         mean_mem[mean_waddr] <= req_value;
      end
      mean_rd_ff <= mean_mem[mean_raddr];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= req_value;
      end
      cnt_rd_ff <= cnt_mem[cnt_raddr];
   end

   // ---------------- datapath terms ----------------
   logic [ACC_W-1:0]   dist_cur;
   logic [ACC_W-1:0]   disc_cur;
   logic signed [31:0] ll_cur;
   logic [30:0]        ex_cur;
   logic [32:0]        diff;
   logic [32:0]        mag;
   logic [64:0]        dist_rnd;
   logic [48:0]        dist_sum;
   logic [ACC_W-1:0]   dist_next;
   logic [40:0]        disc_rnd;
   logic [40:0]        disc_sum;
   logic [ACC_W-1:0]   disc_next;
   logic [30:0]        cnt_pos;
   logic [31:0]        sq_t;
   logic [30:0]        lm_new;
   logic [15:0]        frac_new;
   logic [LOG_W-1:0]   dl;
   logic [41:0]        tsum;
   logic [41:0]        tneg;
   logic signed [31:0] ll_new;
   logic [32:0]        d_exp;
   logic [17:0]        q_raw;
   logic [30:0]        exp_c;
   logic [30:0]        e_shift;
   logic [NUM_W-1:0]   div_num;
   logic               div_done;
   logic [16:0]        div_quo;

   always_comb begin
      dist_cur = dist_ff[k_ff];
      disc_cur = disc_ff[k_ff];
      ll_cur   = ll_ff[k_ff];
      ex_cur   = ex_ff[k_ff];

      // squared distance term, rounded and halved
      diff      = {x_ff[31], x_ff} - {mean_rd_ff[31], mean_rd_ff};
      mag       = diff[32] ? (33'd0 - diff) : diff;
      dist_rnd  = {1'b0, prod_ff[63:0]} + 65'd65536;
      dist_sum  = {9'd0, dist_cur} + {1'b0, dist_rnd[64:17]};
      dist_next = (dist_sum > {9'd0, ACC_MAX}) ? ACC_MAX : dist_sum[ACC_W-1:0];

      // discrete term, ln2 scaled and rounded
      disc_rnd  = {1'b0, prod_ff[39:0]} + 41'd32768;
      disc_sum  = {1'b0, disc_cur} + {16'd0, disc_rnd[40:16]};
      disc_next = (disc_sum > {1'b0, ACC_MAX}) ? ACC_MAX : disc_sum[ACC_W-1:0];

      // negative counts read as zero
      cnt_pos = cnt_rd_ff[31] ? 31'd0 : cnt_rd_ff[30:0];

      // one bit of the log2 fraction from the squared mantissa
      sq_t     = prod_ff[61:30];
      lm_new   = sq_t[31] ? sq_t[31:1] : sq_t[30:0];
      frac_new = lfrac_ff | ({15'd0, sq_t[31]} << (4'd15 - j_ff));
      dl       = lr_ff - {lp_ff, lfrac_ff};

      // total log-likelihood, saturated at the most negative value
      tsum   = {2'd0, dist_cur} + {2'd0, disc_cur} + NORM_TERM;
      tneg   = 42'd0 - tsum;
      ll_new = (tsum > 42'h0_8000_0000) ? LL_MIN : tneg[31:0];

      // exponent operands
      d_exp   = {best_ff[31], best_ff} - {ll_cur[31], ll_cur};
      q_raw   = prod_ff[49:32];
      exp_c   = mpe_pkg::EXP_CONSTS[int'(j_ff) * mpe_pkg::EXP_CW +: mpe_pkg::EXP_CW];
      e_shift = e_ff >> q_ff;

      // posterior numerator with half the divisor for rounding
      div_num = (NUM_W'(ex_cur) << 16) + NUM_W'(sum_ff >> 1);
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_MEAN_MUL: begin
            mul_a = mag;
            mul_b = mag;
         end
         S_LOG_SQ: begin
            mul_a = {2'd0, lm_ff};
            mul_b = {2'd0, lm_ff};
         end
         S_DISC_MUL: begin
            mul_a = 33'(dl);
            mul_b = 33'(mpe_pkg::LN2_Q16);
         end
         S_EXP_MUL: begin
            mul_a = d_exp;
            mul_b = 33'(mpe_pkg::LOG2E_Q16);
         end
         S_EXP_MULC: begin
            mul_a = {2'd0, e_ff};
            mul_b = {2'd0, exp_c};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   mpe_div #(
      .DEN_W (SUM_W),
      .QUO_W (mpe_pkg::POST_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == S_DIV_GO),
      .num      (div_num),
      .den      (sum_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < COMPONENTS; i++) begin
            dist_ff[i] <= '0;
            disc_ff[i] <= '0;
         end
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  x_ff      <= req_value;
                  coord_ff  <= req_coordinate;
                  var_ff    <= req_variable;
                  sel_ff    <= (int'(req_category) < CATEGORIES) ?
                               CAT_W'(req_category) : '0;
                  last_ff   <= req_last;
                  k_ff      <= '0;
                  c_ff      <= '0;
                  rowsum_ff <= '0;
                  best_ff   <= LL_MIN;
                  case (req_opcode)
                     mpe_pkg::OP_COORD: begin
                        if (int'(req_coordinate) < DIMENSIONS) begin
                           state_ff <= S_MEAN_RD;
                        end else if (req_last) begin
                           state_ff <= S_SCORE;
                        end
                     end
                     mpe_pkg::OP_CATEGORY: begin
                        if (int'(req_variable) < DISCRETE_VARS) begin
                           state_ff <= S_ROW_RD;
                        end else if (req_last) begin
                           state_ff <= S_SCORE;
                        end
                     end
                     default: begin
                        state_ff <= S_IDLE;
                     end
                  endcase
               end
            end

            // coordinate: one component per pass
            S_MEAN_RD: begin
               state_ff <= S_MEAN_MUL;
            end
            S_MEAN_MUL: begin
               state_ff <= S_MEAN_ACC;
            end
            S_MEAN_ACC: begin
               dist_ff[k_ff] <= dist_next;
               if (k_ff == COMP_W'(COMPONENTS - 1)) begin
                  k_ff     <= '0;
                  state_ff <= last_ff ? S_SCORE : S_IDLE;
               end else begin
                  k_ff     <= k_ff + COMP_W'(1);
                  state_ff <= S_MEAN_RD;
               end
            end

            // category: walk the count row
            S_ROW_RD: begin
               state_ff <= S_ROW_ADD;
            end
            S_ROW_ADD: begin
               rowsum_ff <= rowsum_ff + RS_W'(cnt_pos);
               if (c_ff == sel_ff) begin
                  cnt_ff <= cnt_pos;
               end
               if (c_ff == CAT_W'(CATEGORIES - 1)) begin
                  state_ff <= S_LOG_START;
               end else begin
                  c_ff     <= c_ff + CAT_W'(1);
                  state_ff <= S_ROW_RD;
               end
            end
            S_LOG_START: begin
               if ((cnt_ff == 31'd0) || (rowsum_ff == '0)) begin
                  disc_ff[k_ff] <= ACC_MAX;
                  c_ff          <= '0;
                  rowsum_ff     <= '0;
                  if (k_ff == COMP_W'(COMPONENTS - 1)) begin
                     k_ff     <= '0;
                     state_ff <= last_ff ? S_SCORE : S_IDLE;
                  end else begin
                     k_ff     <= k_ff + COMP_W'(1);
                     state_ff <= S_ROW_RD;
                  end
               end else begin
                  lw_ff    <= rowsum_ff;
                  lp_ff    <= P_W'(RS_W - 1);
                  lpass_ff <= 1'b0;
                  state_ff <= S_LOG_NORM;
               end
            end
            // find the leading one, one bit a cycle
            S_LOG_NORM: begin
               if (lw_ff[RS_W-1]) begin
                  lm_ff    <= lw_ff[RS_W-1 -: 31];
                  lfrac_ff <= '0;
                  j_ff     <= '0;
                  state_ff <= S_LOG_SQ;
               end else begin
                  lw_ff <= lw_ff << 1;
                  lp_ff <= lp_ff - P_W'(1);
               end
            end
            S_LOG_SQ: begin
               state_ff <= S_LOG_CHK;
            end
            S_LOG_CHK: begin
               lm_ff    <= lm_new;
               lfrac_ff <= frac_new;
               if (j_ff == 4'd15) begin
                  if (!lpass_ff) begin
                     lr_ff    <= {lp_ff, frac_new};
                     lw_ff    <= RS_W'(cnt_ff);
                     lp_ff    <= P_W'(RS_W - 1);
                     lpass_ff <= 1'b1;
                     state_ff <= S_LOG_NORM;
                  end else begin
                     state_ff <= S_DISC_MUL;
                  end
               end else begin
                  j_ff     <= j_ff + 4'd1;
                  state_ff <= S_LOG_SQ;
               end
            end
            S_DISC_MUL: begin
               state_ff <= S_DISC_ACC;
            end
            S_DISC_ACC: begin
               disc_ff[k_ff] <= disc_next;
               c_ff          <= '0;
               rowsum_ff     <= '0;
               if (k_ff == COMP_W'(COMPONENTS - 1)) begin
                  k_ff     <= '0;
                  state_ff <= last_ff ? S_SCORE : S_IDLE;
               end else begin
                  k_ff     <= k_ff + COMP_W'(1);
                  state_ff <= S_ROW_RD;
               end
            end

            // totals and running maximum
            S_SCORE: begin
               ll_ff[k_ff] <= ll_new;
               if (ll_new > best_ff) begin
                  best_ff <= ll_new;
               end
               if (k_ff == COMP_W'(COMPONENTS - 1)) begin
                  k_ff     <= '0;
                  sum_ff   <= '0;
                  state_ff <= S_EXP_MUL;
               end else begin
                  k_ff <= k_ff + COMP_W'(1);
               end
            end

            // e = 2^-(d*log2 e) as a product of root constants
            S_EXP_MUL: begin
               state_ff <= S_EXP_Q;
            end
            S_EXP_Q: begin
               if (q_raw > 18'd30) begin
                  e_ff     <= '0;
                  q_ff     <= '0;
                  state_ff <= S_EXP_DONE;
               end else begin
                  e_ff     <= 31'h4000_0000;
                  q_ff     <= q_raw[4:0];
                  f_ff     <= prod_ff[31:16];
                  j_ff     <= '0;
                  state_ff <= S_EXP_MULC;
               end
            end
            S_EXP_MULC: begin
               state_ff <= S_EXP_UPD;
            end
            S_EXP_UPD: begin
               if (f_ff[4'd15 - j_ff]) begin
                  e_ff <= prod_ff[60:30];
               end
               if (j_ff == 4'd15) begin
                  state_ff <= S_EXP_DONE;
               end else begin
                  j_ff     <= j_ff + 4'd1;
                  state_ff <= S_EXP_MULC;
               end
            end
            S_EXP_DONE: begin
               ex_ff[k_ff] <= e_shift;
               sum_ff      <= sum_ff + SUM_W'(e_shift);
               if (k_ff == COMP_W'(COMPONENTS - 1)) begin
                  k_ff     <= '0;
                  state_ff <= S_DIV_GO;
               end else begin
                  k_ff     <= k_ff + COMP_W'(1);
                  state_ff <= S_EXP_MUL;
               end
            end

            // normalise and hand out one result word per component
            S_DIV_GO: begin
               state_ff <= S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
               if (div_done) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_comp_ff  <= 3'(k_ff);
                  rsp_ll_ff    <= ll_cur;
                  rsp_post_ff  <= div_quo;
                  rsp_last_ff  <= (k_ff == COMP_W'(COMPONENTS - 1));
                  state_ff     <= S_OUT;
               end
            end
            S_OUT: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  if (k_ff == COMP_W'(COMPONENTS - 1)) begin
                     k_ff <= '0;
                     for (int i = 0; i < COMPONENTS; i++) begin
                        dist_ff[i] <= '0;
                        disc_ff[i] <= '0;
                     end
                     state_ff <= S_IDLE;
                  end else begin
                     k_ff     <= k_ff + COMP_W'(1);
                     state_ff <= S_DIV_GO;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_component_out  = rsp_comp_ff;
   assign rsp_log_likelihood = rsp_ll_ff;
   assign rsp_posterior      = rsp_post_ff;
   assign rsp_last_out       = rsp_last_ff;

   // ---------------- assertions ----------------
   a_no_take_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken while a result word is pending");

   a_last_on_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_out) |-> (rsp_component_out == 3'(COMPONENTS - 1)))
      else $error("last flag on a component other than the final one");

   a_post_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_posterior <= 17'd65536))
      else $error("posterior above one");

   a_load_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && ((req_opcode == mpe_pkg::OP_LOAD_MEAN)
                                  || (req_opcode == mpe_pkg::OP_LOAD_COUNT)))
      |=> req_ready)
      else $error("load word did not complete in one cycle");

endmodule
